// ===== sv/gdc_pkg.sv =====
package gdc_pkg;

    // Geometry and screen
    localparam int MAP_SIZE       = 32;
    localparam int SCREEN_COLUMNS = 640;
    localparam int SCREEN_ROWS    = 480;
    localparam int TEX_WIDTH      = 64;

    localparam int MAP_W  = $clog2(MAP_SIZE);
    localparam int ADDR_W = 2 * MAP_W;
    localparam int MAPC_W = MAP_W + 2;          // signed map coordinate, room for -1 and MAP_SIZE
    localparam int TEX_W  = $clog2(TEX_WIDTH);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int LH_W   = $clog2(2 * SCREEN_ROWS + 1);

    // Field widths
    localparam int POS_W   = 21;
    localparam int VEC_W   = 18;
    localparam int CODE_W  = 3;
    localparam int COL_W   = 10;
    localparam int CIDX_W  = 3;

    // Datapath widths
    localparam int DIV_W   = 40;
    localparam int DELTA_W = 32;
    localparam int SIDE_W  = 40;
    localparam int CAM_W   = 19;
    localparam int RAY_W   = 22;
    localparam int PRD_W   = VEC_W + CAM_W;

    localparam int ONE_Q16 = 65536;

    // Camera x: column * 2 * ONE_Q16 / SCREEN_COLUMNS by reciprocal multiplication
    localparam int CAM_SHIFT = 12;
    localparam int CAM_RECIP = (((2 * ONE_Q16) << CAM_SHIFT) + SCREEN_COLUMNS - 1)
                               / SCREEN_COLUMNS;
    localparam int CAM_PRD_W = COL_W + 20;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_POS_X   = 3'd0,
        REG_POS_Y   = 3'd1,
        REG_DIR_X   = 3'd2,
        REG_DIR_Y   = 3'd3,
        REG_PLANE_X = 3'd4,
        REG_PLANE_Y = 3'd5
    } t_reg_idx;

    // Commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

endpackage

// ===== sv/gdc_map_ram.sv =====
module gdc_map_ram
    import gdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [CODE_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [CODE_W-1:0] o_rdata
);

    logic [CODE_W-1:0] r_mem [2**ADDR_W];
    logic [CODE_W-1:0] r_rdata;

    // Write one cell, read one cell, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/gdc_div.sv =====
module gdc_div
    import gdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W-1:0] r_q;
    logic [DIV_W:0]   r_rem;
    logic [DIV_W:0]   rem_sh;
    logic             q_bit;

    // Shift in one dividend bit and try a subtract (zero divisor gives all ones)
    always_comb begin
        rem_sh = {r_rem[DIV_W-1:0], r_q[DIV_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_den});
    end

    // One quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_den  <= i_den;
                r_q    <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= q_bit ? (rem_sh - {1'b0, r_den}) : rem_sh;
                r_q   <= {r_q[DIV_W-2:0], q_bit};
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== sv/grid_dda_wall_column_caster.sv =====
// Grid raycaster, one wall column per cast beat.
// Input channel (i_in_valid / o_in_stall): a beat with i_command = write stores
// i_cell_value at cell (i_cell_x, i_cell_y) and gives no result.
// A beat with i_command = cast traces the ray for screen column i_column and
// gives one result beat on the output channel (o_out_valid / i_out_stall).
// Configuration (i_cfg_valid / o_cfg_ready, always ready) sets the camera
// position, direction and plane; write it only while the block is idle.
// Camera x comes from a reciprocal multiplication. A cast then runs through
// one shared restoring divider four times when it hits a wall (two
// reciprocals, perpendicular distance, line height) and twice when the ray
// leaves the grid, plus a map memory read and a test per grid cell walked.
// One cast is in work at a time; the input stalls until its result is
// registered. The result waits in the output register while i_out_stall is
// high, and the next cast finishes only after that beat has left.
// After reset the map memory is cleared one cell per cycle;
// the input channel stalls during the pass, configuration is taken as ever.
module grid_dda_wall_column_caster
    import gdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_command,
    input  logic [MAP_W-1:0]  i_cell_x,
    input  logic [MAP_W-1:0]  i_cell_y,
    input  logic [CODE_W-1:0] i_cell_value,
    input  logic [COL_W-1:0]  i_column,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [COL_W-1:0]  o_out_column,
    output logic [ROW_W-1:0]  o_draw_start,
    output logic [ROW_W-1:0]  o_draw_end,
    output logic [CODE_W-1:0] o_texture_index,
    output logic [TEX_W-1:0]  o_texture_column,
    output logic              o_hit_side,
    output logic              o_wall_found,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [POS_W-1:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CAM, S_MUL, S_RAY0, S_RAY, S_DX, S_DY,
        S_SX, S_SY, S_STEP, S_LOOK, S_PERP, S_LH, S_WALL, S_FIN
    } t_state;

    t_state r_state;

    // Configuration
    logic [POS_W-1:0]        r_pos_x, r_pos_y;
    logic signed [VEC_W-1:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;

    // Cast datapath
    logic [COL_W-1:0]         r_column;
    logic [ADDR_W-1:0]        r_clr_addr;
    logic signed [CAM_W-1:0]  r_cam;
    logic signed [PRD_W-1:0]  r_prod_x, r_prod_y;
    logic signed [RAY_W-1:0]  r_ray_x, r_ray_y;
    logic [DELTA_W-1:0]       r_dx, r_dy;
    logic [SIDE_W-1:0]        r_sx, r_sy;
    logic signed [MAPC_W-1:0] r_map_x, r_map_y;
    logic                     r_side;
    logic                     r_hit;
    logic [CODE_W-1:0]        r_code;
    logic [DIV_W-1:0]         r_perp;
    logic [LH_W-1:0]          r_lh;
    logic [31:0]              r_wall_prod;

    // Output register
    logic              r_out_valid;
    logic [COL_W-1:0]  r_out_column;
    logic [ROW_W-1:0]  r_draw_start, r_draw_end;
    logic [CODE_W-1:0] r_texture_index;
    logic [TEX_W-1:0]  r_texture_column;
    logic              r_hit_side, r_wall_found;

    // Shared divider
    logic             div_start, div_done;
    logic [DIV_W-1:0] div_num, div_den, div_quot;

    // Map memory
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CODE_W-1:0] ram_wdata, ram_rdata;

    logic in_accept, wr_accept, cast_accept;
    logic [CAM_PRD_W-1:0] cam_prod;
    logic neg_x, neg_y;
    logic [RAY_W-1:0] mag_x, mag_y;
    logic [16:0] f_x, f_y;
    logic [48:0] sx_prod, sy_prod;
    logic [DELTA_W-1:0] quot_sat;
    logic signed [MAPC_W-1:0] n_map_x, n_map_y;
    logic n_out_grid;
    logic signed [MAPC_W+16:0] edge_q, diff;
    logic [MAPC_W+16:0] perp_num;
    logic [RAY_W-1:0] perp_den;
    logic [LH_W-2:0] lh_half;
    logic [15:0] wall_frac;
    logic [TEX_W-1:0] tex_raw;
    logic mirror;
    logic out_free;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign wr_accept   = in_accept && (i_command == CMD_WRITE);
    assign cast_accept = in_accept && (i_command == CMD_CAST);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Scale the column to camera x by the reciprocal of the screen width
    assign cam_prod = CAM_PRD_W'(r_column) * CAM_PRD_W'(CAM_RECIP);

    // Ray signs, magnitudes and distance to the first grid line
    always_comb begin
        neg_x = r_ray_x[RAY_W-1];
        neg_y = r_ray_y[RAY_W-1];
        mag_x = neg_x ? RAY_W'(-r_ray_x) : RAY_W'(r_ray_x);
        mag_y = neg_y ? RAY_W'(-r_ray_y) : RAY_W'(r_ray_y);
        f_x = neg_x ? {1'b0, r_pos_x[15:0]} : 17'(ONE_Q16) - {1'b0, r_pos_x[15:0]};
        f_y = neg_y ? {1'b0, r_pos_y[15:0]} : 17'(ONE_Q16) - {1'b0, r_pos_y[15:0]};
        sx_prod = 49'(f_x) * 49'(r_dx);
        sy_prod = 49'(f_y) * 49'(r_dy);
        quot_sat = (div_quot[DIV_W-1:DELTA_W] != '0) ? '1 : div_quot[DELTA_W-1:0];
    end

    // One DDA step: advance the axis with the nearer grid line
    always_comb begin
        n_map_x = r_map_x;
        n_map_y = r_map_y;
        if (r_sx < r_sy) begin
            n_map_x = neg_x ? r_map_x - 1'b1 : r_map_x + 1'b1;
        end else begin
            n_map_y = neg_y ? r_map_y - 1'b1 : r_map_y + 1'b1;
        end
        n_out_grid = (n_map_x < 0) || (n_map_x >= MAPC_W'(MAP_SIZE))
                  || (n_map_y < 0) || (n_map_y >= MAPC_W'(MAP_SIZE));
    end

    // Perpendicular distance operands on the crossed axis
    always_comb begin
        if (!r_side) begin
            edge_q   = (MAPC_W + 17)'($signed({r_map_x + MAPC_W'(neg_x), 16'b0}));
            diff     = edge_q - $signed((MAPC_W + 17)'(r_pos_x));
            perp_den = mag_x;
        end else begin
            edge_q   = (MAPC_W + 17)'($signed({r_map_y + MAPC_W'(neg_y), 16'b0}));
            diff     = edge_q - $signed((MAPC_W + 17)'(r_pos_y));
            perp_den = mag_y;
        end
        perp_num = diff[MAPC_W+16] ? (MAPC_W + 17)'(-diff) : (MAPC_W + 17)'(diff);
    end

    // Slice rows and texture column
    always_comb begin
        lh_half   = r_lh[LH_W-1:1];
        wall_frac = (r_side ? r_pos_x[15:0] : r_pos_y[15:0]) + r_wall_prod[31:16];
        tex_raw   = wall_frac[15:16-TEX_W];
        mirror    = (!r_side && !neg_x && (r_ray_x != '0)) || (r_side && neg_y);
    end

    // Divider operand select
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (r_state)
            S_RAY: begin
                div_start = 1'b1;
                div_num   = DIV_W'(64'd1 << 32);
                div_den   = DIV_W'(mag_x);
            end
            S_DX: begin
                div_start = div_done;
                div_num   = DIV_W'(64'd1 << 32);
                div_den   = DIV_W'(mag_y);
            end
            S_LOOK: begin
                div_start = (ram_rdata != '0);
                div_num   = DIV_W'({perp_num, 16'b0});
                div_den   = DIV_W'(perp_den);
            end
            S_PERP: begin
                div_start = div_done;
                div_num   = DIV_W'(SCREEN_ROWS * ONE_Q16);
                div_den   = div_quot;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Map memory ports: clearing pass, cell writes, walk reads
    always_comb begin
        ram_we    = (r_state == S_CLEAR) || wr_accept;
        ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : {i_cell_y, i_cell_x};
        ram_wdata = (r_state == S_CLEAR) ? '0 : i_cell_value;
        ram_raddr = {n_map_y[MAP_W-1:0], n_map_x[MAP_W-1:0]};
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= POS_W'(1441792);
            r_pos_y   <= POS_W'(786432);
            r_dir_x   <= -VEC_W'(ONE_Q16);
            r_dir_y   <= '0;
            r_plane_x <= '0;
            r_plane_y <= VEC_W'(43254);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_POS_X:   r_pos_x   <= i_cfg_data;
                REG_POS_Y:   r_pos_y   <= i_cfg_data;
                REG_DIR_X:   r_dir_x   <= i_cfg_data[VEC_W-1:0];
                REG_DIR_Y:   r_dir_y   <= i_cfg_data[VEC_W-1:0];
                REG_PLANE_X: r_plane_x <= i_cfg_data[VEC_W-1:0];
                REG_PLANE_Y: r_plane_y <= i_cfg_data[VEC_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the beat once taken; the final state reloads it itself
            if (r_out_valid && !i_out_stall && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (cast_accept) begin
                        r_column <= i_column;
                        r_state  <= S_CAM;
                    end
                end
                S_CAM: begin
                    r_cam   <= $signed(CAM_W'(cam_prod[CAM_PRD_W-1:CAM_SHIFT]))
                             - $signed(CAM_W'(ONE_Q16));
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod_x <= r_plane_x * r_cam;
                    r_prod_y <= r_plane_y * r_cam;
                    r_state  <= S_RAY0;
                end
                S_RAY0: begin
                    r_ray_x <= RAY_W'(r_dir_x) + RAY_W'(r_prod_x >>> 16);
                    r_ray_y <= RAY_W'(r_dir_y) + RAY_W'(r_prod_y >>> 16);
                    r_map_x <= $signed(MAPC_W'(r_pos_x[POS_W-1:16]));
                    r_map_y <= $signed(MAPC_W'(r_pos_y[POS_W-1:16]));
                    r_state <= S_RAY;
                end
                S_RAY: begin
                    r_state <= S_DX;
                end
                S_DX: begin
                    if (div_done) begin
                        r_dx    <= quot_sat;
                        r_state <= S_DY;
                    end
                end
                S_DY: begin
                    if (div_done) begin
                        r_dy    <= quot_sat;
                        r_state <= S_SX;
                    end
                end
                S_SX: begin
                    r_sx    <= SIDE_W'(sx_prod[48:16]);
                    r_state <= S_SY;
                end
                S_SY: begin
                    r_sy    <= SIDE_W'(sy_prod[48:16]);
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (r_sx < r_sy) begin
                        r_sx   <= r_sx + SIDE_W'(r_dx);
                        r_side <= 1'b0;
                    end else begin
                        r_sy   <= r_sy + SIDE_W'(r_dy);
                        r_side <= 1'b1;
                    end
                    r_map_x <= n_map_x;
                    r_map_y <= n_map_y;
                    if (n_out_grid) begin
                        r_hit   <= 1'b0;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (ram_rdata != '0) begin
                        r_code  <= ram_rdata;
                        r_hit   <= 1'b1;
                        r_state <= S_PERP;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_PERP: begin
                    if (div_done) begin
                        r_perp  <= div_quot;
                        r_state <= S_LH;
                    end
                end
                S_LH: begin
                    if (div_done) begin
                        r_lh <= (div_quot > DIV_W'(2 * SCREEN_ROWS))
                              ? LH_W'(2 * SCREEN_ROWS) : LH_W'(div_quot);
                        r_state <= S_WALL;
                    end
                end
                S_WALL: begin
                    r_wall_prod <= r_perp[31:0] * (r_side ? 32'(r_ray_x) : 32'(r_ray_y));
                    r_state     <= S_FIN;
                end
                S_FIN: begin
                    // hold the result until the output register is free
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_column <= r_column;
                        if (r_hit) begin
                            r_draw_start <= (lh_half >= (LH_W-1)'(SCREEN_ROWS / 2)) ? '0
                                : ROW_W'((LH_W-1)'(SCREEN_ROWS / 2) - lh_half);
                            r_draw_end <= (lh_half >= (LH_W-1)'(SCREEN_ROWS / 2))
                                ? ROW_W'(SCREEN_ROWS - 1)
                                : ROW_W'(lh_half + (LH_W-1)'(SCREEN_ROWS / 2));
                            r_texture_index  <= r_code - 1'b1;
                            r_texture_column <= mirror ? ~tex_raw : tex_raw;
                            r_hit_side       <= r_side;
                            r_wall_found     <= 1'b1;
                        end else begin
                            r_draw_start     <= '0;
                            r_draw_end       <= '0;
                            r_texture_index  <= '0;
                            r_texture_column <= '0;
                            r_hit_side       <= 1'b0;
                            r_wall_found     <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_column     = r_out_column;
    assign o_draw_start     = r_draw_start;
    assign o_draw_end       = r_draw_end;
    assign o_texture_index  = r_texture_index;
    assign o_texture_column = r_texture_column;
    assign o_hit_side       = r_hit_side;
    assign o_wall_found     = r_wall_found;

    gdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    gdc_map_ram u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// ===== tb/tb_grid_dda_wall_column_caster.sv =====
module tb_grid_dda_wall_column_caster;
    import gdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes that the block does not decode
    localparam logic [CIDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CIDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam int SETTLE_CYCLES = 400;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  draw_start;
        logic [ROW_W-1:0]  draw_end;
        logic [CODE_W-1:0] texture_index;
        logic [TEX_W-1:0]  texture_column;
        logic              hit_side;
        logic              wall_found;
    } slice_t;

    typedef struct {
        logic              command;
        logic [MAP_W-1:0]  cell_x;
        logic [MAP_W-1:0]  cell_y;
        logic [CODE_W-1:0] cell_value;
        logic [COL_W-1:0]  column;
        bit                typed;
        slice_t            slice;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_command = 1'b0;
    logic [MAP_W-1:0] i_cell_x = '0;
    logic [MAP_W-1:0] i_cell_y = '0;
    logic [CODE_W-1:0] i_cell_value = '0;
    logic [COL_W-1:0] i_column = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [COL_W-1:0] o_out_column;
    logic [ROW_W-1:0] o_draw_start;
    logic [ROW_W-1:0] o_draw_end;
    logic [CODE_W-1:0] o_texture_index;
    logic [TEX_W-1:0] o_texture_column;
    logic o_hit_side;
    logic o_wall_found;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [POS_W-1:0] i_cfg_data = '0;

    grid_dda_wall_column_caster DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow camera state and wall grid
    logic [POS_W-1:0]        cam_pos_x = 21'd1441792;
    logic [POS_W-1:0]        cam_pos_y = 21'd786432;
    logic signed [VEC_W-1:0] cam_dir_x = -18'sd65536;
    logic signed [VEC_W-1:0] cam_dir_y = 18'sd0;
    logic signed [VEC_W-1:0] cam_plane_x = 18'sd0;
    logic signed [VEC_W-1:0] cam_plane_y = 18'sd43254;
    logic [CODE_W-1:0]       wall_grid [MAP_SIZE*MAP_SIZE];

    slice_t pending_slices[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    function automatic longint step_length(longint r);
        longint m;
        m = (r < 0) ? -r : r;
        if (m == 0) return 64'hFFFF_FFFF;
        if (((64'd1 << 32) / m) > 64'hFFFF_FFFF) return 64'hFFFF_FFFF;
        return (64'd1 << 32) / m;
    endfunction

    // Trace one column through the shadow grid
    function automatic slice_t trace_column(logic [COL_W-1:0] col);
        slice_t s;
        longint cam, rx, ry, mx, my, stx, sty, dx, dy, fx, fy, sdx, sdy;
        longint num, den, perp, lh, ds, de, wall, tex;
        int side;
        bit hit;
        logic [CODE_W-1:0] code;
        s = '0;
        side = 0;
        hit = 0;
        code = '0;
        cam = (longint'(col) * 2 * ONE_Q16) / SCREEN_COLUMNS - ONE_Q16;
        rx = longint'(cam_dir_x) + ((longint'(cam_plane_x) * cam) >>> 16);
        ry = longint'(cam_dir_y) + ((longint'(cam_plane_y) * cam) >>> 16);
        mx = longint'(cam_pos_x >> 16);
        my = longint'(cam_pos_y >> 16);
        dx = step_length(rx);
        dy = step_length(ry);
        fx = longint'(cam_pos_x[15:0]);
        fy = longint'(cam_pos_y[15:0]);
        if (rx < 0) stx = -1;
        else begin
            stx = 1;
            fx = ONE_Q16 - fx;
        end
        if (ry < 0) sty = -1;
        else begin
            sty = 1;
            fy = ONE_Q16 - fy;
        end
        sdx = (fx * dx) >> 16;
        sdy = (fy * dy) >> 16;
        forever begin
            if (sdx < sdy) begin
                sdx += dx;
                mx += stx;
                side = 0;
            end else begin
                sdy += dy;
                my += sty;
                side = 1;
            end
            if (mx < 0 || mx >= MAP_SIZE || my < 0 || my >= MAP_SIZE) break;
            code = wall_grid[my * MAP_SIZE + mx];
            if (code != 0) begin
                hit = 1;
                break;
            end
        end
        s.column = col;
        if (!hit) return s;
        if (side == 0) begin
            num = (mx + (stx < 0 ? 1 : 0)) * ONE_Q16 - longint'(cam_pos_x);
            den = rx;
        end else begin
            num = (my + (sty < 0 ? 1 : 0)) * ONE_Q16 - longint'(cam_pos_y);
            den = ry;
        end
        if (num < 0) num = -num;
        if (den < 0) den = -den;
        perp = (den == 0) ? 64'hFF_FFFF_FFFF : (num << 16) / den;
        if (perp > 64'hFF_FFFF_FFFF) perp = 64'hFF_FFFF_FFFF;
        lh = (perp == 0) ? 2 * SCREEN_ROWS : (longint'(SCREEN_ROWS) << 16) / perp;
        if (lh > 2 * SCREEN_ROWS) lh = 2 * SCREEN_ROWS;
        ds = SCREEN_ROWS / 2 - lh / 2;
        if (ds < 0) ds = 0;
        de = lh / 2 + SCREEN_ROWS / 2;
        if (de >= SCREEN_ROWS) de = SCREEN_ROWS - 1;
        if (side == 0) wall = longint'(cam_pos_y) + ((perp * ry) >>> 16);
        else wall = longint'(cam_pos_x) + ((perp * rx) >>> 16);
        tex = ((wall & 64'hFFFF) * TEX_WIDTH) >> 16;
        if ((side == 0 && rx > 0) || (side == 1 && ry < 0)) tex = TEX_WIDTH - tex - 1;
        s.draw_start = ROW_W'(ds);
        s.draw_end = ROW_W'(de);
        s.texture_index = code - 1'b1;
        s.texture_column = TEX_W'(tex);
        s.hit_side = 1'(side);
        s.wall_found = 1'b1;
        return s;
    endfunction

    // Send one beat, then apply it to the shadow state; valid stays up for the next one
    task automatic send_item(row_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= r.command;
        i_cell_x <= r.cell_x;
        i_cell_y <= r.cell_y;
        i_cell_value <= r.cell_value;
        i_column <= r.column;
        do @(posedge i_clk); while (o_in_stall);
        if (r.command == CMD_WRITE) wall_grid[{r.cell_y, r.cell_x}] = r.cell_value;
        else pending_slices.push_back(r.typed ? r.slice : trace_column(r.column));
        @(negedge i_clk);
    endtask

    // Write one register; valid stays up for the next write
    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [POS_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_POS_X:   cam_pos_x = val;
            REG_POS_Y:   cam_pos_y = val;
            REG_DIR_X:   cam_dir_x = val[VEC_W-1:0];
            REG_DIR_Y:   cam_dir_y = val[VEC_W-1:0];
            REG_PLANE_X: cam_plane_x = val[VEC_W-1:0];
            REG_PLANE_Y: cam_plane_y = val[VEC_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_slices.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Receiver stall
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        slice_t got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_out_column, o_draw_start, o_draw_end, o_texture_index,
                    o_texture_column, o_hit_side, o_wall_found};
            if (pending_slices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
            end else begin
                want = pending_slices.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("expected %p got %p", want, got);
                end
            end
        end
    end

    function automatic row_t wr(int x, int y, int v);
        row_t r;
        r = '{default: '0};
        r.command = CMD_WRITE;
        r.cell_x = MAP_W'(x);
        r.cell_y = MAP_W'(y);
        r.cell_value = CODE_W'(v);
        return r;
    endfunction

    function automatic row_t cast(int col, bit typed = 0, slice_t s = '0);
        row_t r;
        r = '{default: '0};
        r.command = CMD_CAST;
        r.column = COL_W'(col);
        r.typed = typed;
        r.slice = s;
        return r;
    endfunction

    initial begin
        row_t directed[$];
        row_t r;
        logic [POS_W-1:0] cfg [6];
        foreach (wall_grid[k]) wall_grid[k] = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty map: every ray leaves the grid
        directed.push_back(cast(0, 1, '{10'd0, 0, 0, 0, 0, 0, 0}));
        directed.push_back(cast(639, 1, '{10'd639, 0, 0, 0, 0, 0, 0}));
        directed.push_back(cast(1023, 1, '{10'd1023, 0, 0, 0, 0, 0, 0}));
        // Camera on a grid line facing a wall: zero distance, full screen
        directed.push_back(wr(21, 12, 3));
        directed.push_back(cast(320, 1, '{10'd320, 9'd0, 9'd479, 3'd2, 6'd0, 1'b0, 1'b1}));
        directed.push_back(wr(21, 12, 0));
        directed.push_back(wr(0, 12, 1));
        directed.push_back(wr(31, 31, 7));
        directed.push_back(wr(0, 0, 7));
        directed.push_back(cast(320));
        for (int k = 0; k < 32; k += 4) directed.push_back(wr(k, 0, 5));
        directed.push_back(cast(0));
        directed.push_back(cast(639));
        directed.push_back(cast(1023));
        directed.push_back(cast(700));
        directed.push_back(wr(31, 0, 2));
        directed.push_back(cast(100));
        foreach (directed[k]) send_item(directed[k]);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            // Camera setting for this phase
            case (phase)
                0: cfg = '{21'd1441792, 21'd786432, 21'h3_0000, 21'd0, 21'd0, 21'd43254};
                1: cfg = '{21'h1F_FFFF, 21'h1F_FFFF, 21'h1_FFFF, 21'h2_0000,
                           21'h2_0000, 21'h1_FFFF};
                2: cfg = '{21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0};
                3: cfg = '{21'h10_0000, 21'h10_8000, 21'h2_0000, 21'h1_FFFF,
                           21'h1_FFFF, 21'h2_0000};
                default: begin
                    cfg[0] = POS_W'($urandom_range(21'h1F_FFFF, 21'h1_0000));
                    cfg[1] = POS_W'($urandom_range(21'h1F_FFFF, 21'h1_0000));
                    if (phase == 4) cfg[0][15:0] = '0;
                    for (int k = 2; k < 6; k++) cfg[k] = POS_W'($urandom);
                end
            endcase
            write_reg(REG_POS_X, cfg[0]);
            write_reg(REG_POS_Y, cfg[1]);
            write_reg(REG_DIR_X, cfg[2]);
            write_reg(REG_DIR_Y, cfg[3]);
            write_reg(REG_PLANE_X, cfg[4]);
            write_reg(REG_PLANE_Y, cfg[5]);
            write_reg(REG_SPARE_6, POS_W'($urandom));
            write_reg(REG_SPARE_7, POS_W'($urandom));
            i_cfg_valid <= 1'b0;

            // Map edits mixed with casts, mostly on screen
            for (int n = 0; n < 205; n++) begin
                if ($urandom_range(99) < 40)
                    r = wr($urandom_range(31), $urandom_range(31),
                           ($urandom_range(99) < 35) ? 0 : $urandom_range(7, 1));
                else if ($urandom_range(99) < 6)
                    r = cast($urandom_range(1023, 640));
                else
                    r = cast($urandom_range(639));
                send_item(r);
            end
            drain();
        end

        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #30ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== grid_dda_wall_column_caster.f =====
sv/gdc_pkg.sv
sv/gdc_map_ram.sv
sv/gdc_div.sv
sv/grid_dda_wall_column_caster.sv
tb/tb_grid_dda_wall_column_caster.sv
